@@ sv/fat_chain_allocator_macros.svh @@
// assertion macros for the allocator, clocked on i_clk, off while i_rst_n is low
`ifndef FAT_CHAIN_ALLOCATOR_MACROS_SVH
`define FAT_CHAIN_ALLOCATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define FCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FCA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/fca_pkg.sv @@
package fca_pkg;

    // fixed field widths of the request and result
    localparam int KEY_W    = 16;
    localparam int CNT_W    = 8;
    localparam int STATUS_W = 3;
    localparam int START_W  = 8;
    localparam int FREE_W   = 8;

    // request function codes
    localparam logic FN_CREATE = 1'b0;
    localparam logic FN_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_BIG   = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DIR_FULL  = 3'd4
    } t_status;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] file_key;
        logic [CNT_W-1:0] block_count;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [START_W-1:0] start_block;
        logic [FREE_W-1:0]  free_blocks;
    } t_resp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PRECHK,
        S_DSCAN,
        S_ASCAN,
        S_AFIN,
        S_WREAD,
        S_WEVAL,
        S_DFIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    latch;
        logic    scan_init;
        logic    scan_blk;
        logic    clear;
        logic    dscan;
        logic    ascan;
        logic    afin;
        logic    walk_init;
        logic    walk_free;
        logic    dfin;
        logic    result;
        t_status status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic too_big;
        logic found;
        logic empty_found;
        logic scan_end;
        logic alloc_done;
        logic walk_done;
        logic chain_free;
        logic clear_done;
    } t_stat;

endpackage

@@ sv/fca_ram.sv @@
module fca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/fca_ctrl.sv @@
module fca_ctrl import fca_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_PRECHK;
                end
            end
            S_PRECHK: begin
                if (i_stat.func == FN_CREATE && i_stat.too_big) begin
                    o_cmd.result = 1'b1;
                    o_cmd.status = ST_TOO_BIG;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_DSCAN;
                end
            end
            S_DSCAN: begin
                o_cmd.dscan = 1'b1;
                if (i_stat.found || i_stat.scan_end) begin
                    if (i_stat.func == FN_DELETE) begin
                        if (i_stat.found) begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_WREAD;
                        end else begin
                            o_cmd.result = 1'b1;
                            o_cmd.status = ST_NOT_FOUND;
                            n_state      = S_IDLE;
                        end
                    end else if (i_stat.found) begin
                        o_cmd.result = 1'b1;
                        o_cmd.status = ST_EXISTS;
                        n_state      = S_IDLE;
                    end else if (!i_stat.empty_found) begin
                        o_cmd.result = 1'b1;
                        o_cmd.status = ST_DIR_FULL;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        o_cmd.scan_blk  = 1'b1;
                        n_state         = S_ASCAN;
                    end
                end
            end
            S_ASCAN: begin
                o_cmd.ascan = 1'b1;
                if (i_stat.alloc_done) begin
                    n_state = S_AFIN;
                end
            end
            S_AFIN: begin
                o_cmd.afin   = 1'b1;
                o_cmd.result = 1'b1;
                n_state      = S_IDLE;
            end
            S_WREAD: begin
                if (i_stat.walk_done) begin
                    n_state = S_DFIN;
                end else begin
                    n_state = S_WEVAL;
                end
            end
            S_WEVAL: begin
                if (i_stat.chain_free) begin
                    n_state = S_DFIN;
                end else begin
                    o_cmd.walk_free = 1'b1;
                    n_state         = S_WREAD;
                end
            end
            S_DFIN: begin
                o_cmd.dfin   = 1'b1;
                o_cmd.result = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ sv/fca_dpath.sv @@
module fca_dpath import fca_pkg::*; #(
    parameter int NUM_BLOCKS = 128,
    parameter int NUM_SLOTS  = 32,
    parameter int KEY_BITS   = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_resp o_resp,
    output logic  o_done
);

    localparam int BW       = $clog2(NUM_BLOCKS);
    localparam int SAW      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW       = (BW > SAW) ? BW : SAW;
    localparam int CW       = $clog2(NUM_BLOCKS + 2);
    localparam int FW       = $clog2(NUM_BLOCKS + 1);
    localparam int KW       = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int DW       = 1 + KW + CW + CNT_W;
    localparam int CMPW     = (FW > CNT_W) ? FW : CNT_W;
    localparam int CLR_LAST = ((NUM_BLOCKS > NUM_SLOTS) ? NUM_BLOCKS : NUM_SLOTS) - 1;

    localparam logic [CW-1:0] C_END  = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0] C_FREE = CW'(NUM_BLOCKS + 1);

    typedef struct packed {
        logic             valid;
        logic [KW-1:0]    key;
        logic [CW-1:0]    start;
        logic [CNT_W-1:0] count;
    } t_dir_ent;

    // scan control
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_issued_all, n_issued_all;
    logic             r_rd_vld, n_rd_vld;
    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_scan_end, n_scan_end;
    logic             r_blk_mode, n_blk_mode;
    // directory search
    logic             r_found, n_found;
    logic             r_empty_found, n_empty_found;
    logic [SAW-1:0]   r_match_idx, n_match_idx;
    logic [SAW-1:0]   r_empty_idx, n_empty_idx;
    logic [CW-1:0]    r_match_start, n_match_start;
    logic [CNT_W-1:0] r_match_cnt, n_match_cnt;
    // allocation and walk
    t_req             r_req, n_req;
    logic [CNT_W-1:0] r_taken, n_taken;
    logic [BW-1:0]    r_prev, n_prev;
    logic [CW-1:0]    r_start, n_start;
    logic [CW-1:0]    r_cur, n_cur;
    logic [FW-1:0]    r_steps, n_steps;
    logic [FW-1:0]    r_free, n_free;
    // result
    t_resp            r_resp, n_resp;
    logic             r_done, n_done;

    logic             chain_we;
    logic [BW-1:0]    chain_waddr;
    logic [CW-1:0]    chain_wdata;
    logic [BW-1:0]    chain_raddr;
    logic [CW-1:0]    chain_rdata;
    logic             dir_we;
    logic [SAW-1:0]   dir_waddr;
    t_dir_ent         dir_wdata;
    logic [DW-1:0]    dir_rdata;
    t_dir_ent         dir_ent;

    logic [IW-1:0]    scan_last;
    logic [CMPW:0]    free_sum;
    logic             take;

    assign dir_ent   = t_dir_ent'(dir_rdata);
    assign scan_last = r_blk_mode ? IW'(NUM_BLOCKS - 1) : IW'(NUM_SLOTS - 1);
    assign free_sum  = (CMPW + 1)'(r_free) + (CMPW + 1)'(r_match_cnt);
    assign take      = i_cmd.ascan && r_rd_vld && (chain_rdata == C_FREE)
                       && (r_taken != r_req.block_count);

    assign chain_raddr = i_cmd.ascan ? r_idx[BW-1:0] : r_cur[BW-1:0];

    fca_ram #(.WIDTH(CW), .DEPTH(NUM_BLOCKS)) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (chain_we),
        .i_waddr (chain_waddr),
        .i_wdata (chain_wdata),
        .i_raddr (chain_raddr),
        .o_rdata (chain_rdata)
    );

    fca_ram #(.WIDTH(DW), .DEPTH(NUM_SLOTS)) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (DW'(dir_wdata)),
        .i_raddr (r_idx[SAW-1:0]),
        .o_rdata (dir_rdata)
    );

    // memory write ports
    always_comb begin
        chain_we    = 1'b0;
        chain_waddr = r_prev;
        chain_wdata = C_END;
        dir_we      = 1'b0;
        dir_waddr   = r_empty_idx;
        dir_wdata   = '0;
        if (i_cmd.clear) begin
            chain_we    = ({1'b0, r_idx} < (IW + 1)'(NUM_BLOCKS));
            chain_waddr = r_idx[BW-1:0];
            chain_wdata = C_FREE;
            dir_we      = ({1'b0, r_idx} < (IW + 1)'(NUM_SLOTS));
            dir_waddr   = r_idx[SAW-1:0];
        end else if (take) begin
            // link the previous block to the one just found
            chain_we    = (r_taken != '0);
            chain_wdata = CW'(r_rd_idx[BW-1:0]);
        end else if (i_cmd.afin) begin
            chain_we        = (r_taken != '0);
            dir_we          = 1'b1;
            dir_wdata.valid = 1'b1;
            dir_wdata.key   = r_req.file_key[KW-1:0];
            dir_wdata.start = r_start;
            dir_wdata.count = r_taken;
        end else if (i_cmd.walk_free) begin
            chain_we    = 1'b1;
            chain_waddr = r_cur[BW-1:0];
            chain_wdata = C_FREE;
        end else if (i_cmd.dfin) begin
            dir_we    = 1'b1;
            dir_waddr = r_match_idx;
        end
    end

    always_comb begin
        n_idx         = r_idx;
        n_issued_all  = r_issued_all;
        n_rd_vld      = 1'b0;
        n_rd_idx      = r_rd_idx;
        n_scan_end    = r_scan_end;
        n_blk_mode    = r_blk_mode;
        n_found       = r_found;
        n_empty_found = r_empty_found;
        n_match_idx   = r_match_idx;
        n_empty_idx   = r_empty_idx;
        n_match_start = r_match_start;
        n_match_cnt   = r_match_cnt;
        n_req         = r_req;
        n_taken       = r_taken;
        n_prev        = r_prev;
        n_start       = r_start;
        n_cur         = r_cur;
        n_steps       = r_steps;
        n_free        = r_free;
        n_resp        = r_resp;
        n_done        = 1'b0;

        if (i_cmd.latch) begin
            n_req         = i_req;
            n_found       = 1'b0;
            n_empty_found = 1'b0;
            n_taken       = '0;
            n_start       = C_END;
        end

        if (i_cmd.clear) begin
            n_idx = r_idx + IW'(1);
        end else if (i_cmd.scan_init) begin
            n_idx        = '0;
            n_issued_all = 1'b0;
            n_scan_end   = 1'b0;
            n_blk_mode   = i_cmd.scan_blk;
        end else if (i_cmd.dscan || i_cmd.ascan) begin
            n_rd_vld = !r_issued_all;
            n_rd_idx = r_idx;
            if (!r_issued_all) begin
                if (r_idx == scan_last) begin
                    n_issued_all = 1'b1;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            if (r_rd_vld && r_rd_idx == scan_last) begin
                n_scan_end = 1'b1;
            end
        end

        // directory compare on the entry read last cycle
        if (i_cmd.dscan && r_rd_vld) begin
            if (dir_ent.valid && dir_ent.key == r_req.file_key[KW-1:0] && !r_found) begin
                n_found       = 1'b1;
                n_match_idx   = r_rd_idx[SAW-1:0];
                n_match_start = dir_ent.start;
                n_match_cnt   = dir_ent.count;
            end
            if (!dir_ent.valid && !r_empty_found) begin
                n_empty_found = 1'b1;
                n_empty_idx   = r_rd_idx[SAW-1:0];
            end
        end

        if (take) begin
            if (r_taken == '0) begin
                n_start = CW'(r_rd_idx[BW-1:0]);
            end
            n_prev  = r_rd_idx[BW-1:0];
            n_taken = r_taken + CNT_W'(1);
        end

        if (i_cmd.afin) begin
            n_free = r_free - FW'(r_taken);
        end

        if (i_cmd.walk_init) begin
            n_cur   = r_match_start;
            n_steps = '0;
            n_start = r_match_start;
        end

        if (i_cmd.walk_free) begin
            n_cur   = chain_rdata;
            n_steps = r_steps + FW'(1);
        end

        if (i_cmd.dfin) begin
            if (free_sum > (CMPW + 1)'(NUM_BLOCKS)) begin
                n_free = FW'(NUM_BLOCKS);
            end else begin
                n_free = FW'(free_sum);
            end
        end

        if (i_cmd.result) begin
            n_done             = 1'b1;
            n_resp.status      = i_cmd.status;
            n_resp.start_block = (i_cmd.status == ST_OK) ? START_W'(n_start) : START_W'(C_END);
            n_resp.free_blocks = FREE_W'(n_free);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_issued_all  <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_scan_end    <= 1'b0;
            r_blk_mode    <= 1'b0;
            r_found       <= 1'b0;
            r_empty_found <= 1'b0;
            r_free        <= FW'(NUM_BLOCKS);
            r_done        <= 1'b0;
        end else begin
            r_idx         <= n_idx;
            r_issued_all  <= n_issued_all;
            r_rd_vld      <= n_rd_vld;
            r_scan_end    <= n_scan_end;
            r_blk_mode    <= n_blk_mode;
            r_found       <= n_found;
            r_empty_found <= n_empty_found;
            r_free        <= n_free;
            r_done        <= n_done;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_idx      <= n_rd_idx;
        r_match_idx   <= n_match_idx;
        r_empty_idx   <= n_empty_idx;
        r_match_start <= n_match_start;
        r_match_cnt   <= n_match_cnt;
        r_req         <= n_req;
        r_taken       <= n_taken;
        r_prev        <= n_prev;
        r_start       <= n_start;
        r_cur         <= n_cur;
        r_steps       <= n_steps;
        r_resp        <= n_resp;
    end

    assign o_stat.func        = r_req.func;
    assign o_stat.too_big     = (CMPW'(r_req.block_count) > CMPW'(r_free));
    assign o_stat.found       = r_found;
    assign o_stat.empty_found = r_empty_found;
    assign o_stat.scan_end    = r_scan_end;
    assign o_stat.alloc_done  = (r_taken == r_req.block_count) || r_scan_end;
    assign o_stat.walk_done   = (r_cur >= C_END) || (r_steps >= FW'(NUM_BLOCKS));
    assign o_stat.chain_free  = (chain_rdata == C_FREE);
    assign o_stat.clear_done  = (r_idx == IW'(CLR_LAST));

    assign o_resp = r_resp;
    assign o_done = r_done;

endmodule

@@ sv/fat_chain_allocator.sv @@
// Linked file allocator: each request creates or deletes a file named by a numeric key.
// A request is taken when start is high and busy is low; its single result appears on
// o_resp for exactly one cycle with o_done high and cannot be held off by the receiver.
// After reset the block clears its allocation table and directory, one entry of each per
// cycle, and stays busy until the clearing pass is done. A create walks the directory
// memory once, one slot per cycle, stopping early if the key is found, then scans the
// table memory from block 0 upward one block per cycle until the requested count is
// taken. A delete stops the directory search at the matching slot, then frees its chain
// one block at a time, reading each link before freeing its block (the next link is
// known only once the registered table read returns). Rejections (too big, duplicate,
// not found, directory full) return right after the check that fails.
`include "fat_chain_allocator_macros.svh"

module fat_chain_allocator import fca_pkg::*; #(
    parameter int NUM_BLOCKS = 128,
    parameter int NUM_SLOTS  = 32,
    parameter int KEY_BITS   = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_req  i_req,
    output logic  busy,
    output logic  o_done,
    output t_resp o_resp
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: clearing pass, directory search, allocation scan, chain walk
    fca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: table and directory memories, scan counters, free count, result register
    fca_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NUM_SLOTS  (NUM_SLOTS),
        .KEY_BITS   (KEY_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_resp  (o_resp),
        .o_done  (o_done)
    );

    // a taken request keeps the block busy into the next cycle
    `FCA_ASSERT_NXT(a_req_busy, start && !busy, busy, "request taken but block not busy")
    // every request passes the check state before its result, so strobes never touch
    `FCA_ASSERT_NXT(a_done_pulse, o_done, !o_done, "result strobe longer than one cycle")
    // an error result never reports a chain
    `FCA_ASSERT_NOW(a_err_nochain, o_done && o_resp.status != ST_OK,
        o_resp.start_block == START_W'(NUM_BLOCKS), "error result carries a start block")
    // the result is shown only when the sequencer is back at rest
    `FCA_ASSERT_NOW(a_done_idle, o_done, !busy, "result shown while still busy")

endmodule
